### rtl/ipv4p_pkg.sv
// Package for the IPv4 text address parser: character codes, limits and word types.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package ipv4p_pkg;

  localparam logic [7:0]  CHAR_ZERO = 8'h30;
  localparam logic [7:0]  CHAR_NINE = 8'h39;
  localparam logic [7:0]  CHAR_DOT  = 8'h2E;

  localparam logic [31:0] MAX_DIV10 = 32'd429496729;
  localparam logic [3:0]  MAX_MOD10 = 4'd5;
  localparam logic [31:0] BYTE_MAX  = 32'd255;

  localparam logic [2:0]  LAST_PART = 3'd3;
  localparam logic [1:0]  COUNT_SAT = 2'd3;

  typedef struct packed {
    logic [7:0] character;
    logic       is_end;
  } char_word_t;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] address;
  } result_word_t;

endpackage

`default_nettype wire

### rtl/ipv4p_if.sv
// Handshake channels of the IPv4 text address parser: character input and result output.
// Does not depend on ipv4p_pkg; the payload widths are written out here.
`timescale 1ns / 1ps
`default_nettype none

interface ipv4p_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       is_end;

  modport source (output valid, output character, output is_end, input ready);
  modport sink   (input valid, input character, input is_end, output ready);
endinterface

interface ipv4p_result_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] address;

  modport source (output valid, output valid_res, output address, input ready);
  modport sink   (input valid, input valid_res, input address, output ready);
endinterface

`default_nettype wire

### rtl/ipv4_text_address_parser_top.sv
// Top level of the IPv4 text address parser: parse state, next-state logic, result register.
// Depends on ipv4p_pkg and the channel interfaces in ipv4p_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Reads an address string one character word per cycle and closes it with an end word
// (is_end set). Each end word yields one result word: valid_res and the 32-bit address,
// either a single decimal integer or four dotted parts of up to three digits each.
// Character words cause no result. A word is taken every cycle unless input is held off;
// the per-character step is one multiply-by-ten and compare between the parse registers,
// and the end word's result goes into a one-word output register. Input is held off only
// while that register is full and not being taken. Parse state clears after every end word.
module ipv4_text_address_parser_top (
  input  wire logic             clk,
  input  wire logic             rst,
  ipv4p_char_if.sink            chars,
  ipv4p_result_if.source        result
);

  logic [2:0]  part_index,        part_index_next;
  logic [31:0] part_accumulator,  part_accumulator_next;
  logic [1:0]  digits_in_part,    digits_in_part_next;
  logic [23:0] upper_bytes,       upper_bytes_next;
  logic [1:0]  char_count,        char_count_next;
  logic        expect_digit,      expect_digit_next;
  logic        leading_zero_part, leading_zero_part_next;
  logic        rejected,          rejected_next;

  logic                  res_valid;
  ipv4p_pkg::result_word_t res_word, res_word_next;

  logic        accept;
  logic        is_digit;
  logic [3:0]  digit;
  logic [31:0] times_ten;
  logic [1:0]  digits_inc;
  logic        ok;

  assign chars.ready = !res_valid || result.ready;
  assign accept      = chars.valid && chars.ready;
  assign is_digit    = (chars.character >= ipv4p_pkg::CHAR_ZERO) &&
                       (chars.character <= ipv4p_pkg::CHAR_NINE);
  assign digit       = 4'(chars.character - ipv4p_pkg::CHAR_ZERO);
  assign times_ten   = (part_accumulator << 3) + (part_accumulator << 1) + 32'(digit);
  assign digits_inc  = (digits_in_part < ipv4p_pkg::COUNT_SAT) ? digits_in_part + 2'd1
                                                                 : digits_in_part;

  assign ok = !rejected && (char_count != 2'd0) && !expect_digit &&
              ((part_index == 3'd0) || (part_index == ipv4p_pkg::LAST_PART));

  always_comb begin
    part_index_next        = part_index;
    part_accumulator_next  = part_accumulator;
    digits_in_part_next    = digits_in_part;
    upper_bytes_next       = upper_bytes;
    char_count_next        = char_count;
    expect_digit_next      = expect_digit;
    leading_zero_part_next = leading_zero_part;
    rejected_next          = rejected;
    if (accept && chars.is_end) begin
      part_index_next        = 3'd0;
      part_accumulator_next  = 32'd0;
      digits_in_part_next    = 2'd0;
      upper_bytes_next       = 24'd0;
      char_count_next        = 2'd0;
      expect_digit_next      = 1'b1;
      leading_zero_part_next = 1'b0;
      rejected_next          = 1'b0;
    end else if (accept) begin
      if (char_count < ipv4p_pkg::COUNT_SAT) begin
        char_count_next = char_count + 2'd1;
      end
      if (!rejected) begin
        if (is_digit) begin
          if (leading_zero_part) begin
            rejected_next = 1'b1;
          end else if ((part_index == 3'd0) &&
                       ((part_accumulator > ipv4p_pkg::MAX_DIV10) ||
                        ((part_accumulator == ipv4p_pkg::MAX_DIV10) &&
                         (digit > ipv4p_pkg::MAX_MOD10)))) begin
            rejected_next = 1'b1;
          end else if ((part_index != 3'd0) && (digits_in_part == ipv4p_pkg::COUNT_SAT)) begin
            rejected_next = 1'b1;
          end else begin
            if ((digits_in_part == 2'd0) && (digit == 4'd0)) begin
              leading_zero_part_next = 1'b1;
            end
            part_accumulator_next = times_ten;
            digits_in_part_next   = digits_inc;
            if ((part_index != 3'd0) && (digits_inc == ipv4p_pkg::COUNT_SAT) &&
                (times_ten > ipv4p_pkg::BYTE_MAX)) begin
              rejected_next = 1'b1;
            end else begin
              expect_digit_next = 1'b0;
            end
          end
        end else if (chars.character == ipv4p_pkg::CHAR_DOT) begin
          if (expect_digit || (part_index >= ipv4p_pkg::LAST_PART) ||
              (part_accumulator > ipv4p_pkg::BYTE_MAX)) begin
            rejected_next = 1'b1;
          end else begin
            upper_bytes_next       = {upper_bytes[15:0], part_accumulator[7:0]};
            part_index_next        = part_index + 3'd1;
            part_accumulator_next  = 32'd0;
            digits_in_part_next    = 2'd0;
            expect_digit_next      = 1'b1;
            leading_zero_part_next = 1'b0;
          end
        end else begin
          rejected_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_word_next.valid_res = ok;
    if (!ok) begin
      res_word_next.address = 32'd0;
    end else if (part_index == 3'd0) begin
      res_word_next.address = part_accumulator;
    end else begin
      res_word_next.address = {upper_bytes, part_accumulator[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_index        <= 3'd0;
      part_accumulator  <= 32'd0;
      digits_in_part    <= 2'd0;
      upper_bytes       <= 24'd0;
      char_count        <= 2'd0;
      expect_digit      <= 1'b1;
      leading_zero_part <= 1'b0;
      rejected          <= 1'b0;
      res_valid         <= 1'b0;
    end else begin
      part_index        <= part_index_next;
      part_accumulator  <= part_accumulator_next;
      digits_in_part    <= digits_in_part_next;
      upper_bytes       <= upper_bytes_next;
      char_count        <= char_count_next;
      expect_digit      <= expect_digit_next;
      leading_zero_part <= leading_zero_part_next;
      rejected          <= rejected_next;
      if (accept && chars.is_end) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && chars.is_end) begin
      res_word <= res_word_next;
    end
  end

  assign result.valid     = res_valid;
  assign result.valid_res = res_word.valid_res;
  assign result.address   = res_word.address;

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_word.valid_res) |-> (res_word.address == 32'd0))
    else $error("rejected result carries a nonzero address");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && chars.is_end) |=> (expect_digit && !rejected && (char_count == 2'd0) &&
                                  (part_index == 3'd0)))
    else $error("parse state not cleared after end word");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(accept && chars.is_end))
    else $error("result appeared without an end word");

  a_reject_sticky: assert property (@(posedge clk) disable iff (rst)
    (rejected && !(accept && chars.is_end)) |=> rejected)
    else $error("rejection dropped before end word");

endmodule

`default_nettype wire
